[rtl/skaf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skaf_pkg
// Register map, widths and reset values of the scalar angle filter.
// ----------------------------------------------------------------------------
package skaf_pkg;

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        REG_STEP_TIME     = 2'd0,
        REG_PROCESS_NOISE = 2'd1,
        REG_MEAS_NOISE    = 2'd2
    } t_reg_idx;

    localparam logic [15:0] STEP_TIME_RST     = 16'd655;
    localparam logic [31:0] PROCESS_NOISE_RST = 32'd0;
    localparam logic [31:0] MEAS_NOISE_RST    = 32'd65536;

    localparam logic req_restart = 1'b1;

endpackage

[rtl/scalar_kalman_angle_filter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scalar_kalman_angle_filter
// One-dimensional angle filter fusing a measured angle with an angular rate.
// ----------------------------------------------------------------------------
// An update item predicts x += w*dt and p += q, forms the gain k = p/(p+r)
// with a restoring divider (one quotient bit per cycle, FRAC_BITS+1 quotient bits),
// then corrects x by k*(e-x) and sets p to (1-k)*p; a restart item clears x
// and p. All products run through one shared registered multiplier under a
// small sequencer. A restart item goes from idle straight to the output
// state; an update item passes through the prediction, divider and
// correction states. o_ready is high only while the block is idle, and
// the result stays on the output ports until it is taken. Configuration
// goes through the APB port at byte addresses 0, 4 and 8.
// ----------------------------------------------------------------------------
module scalar_kalman_angle_filter
    import skaf_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready,

    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_req_type,
    input  logic signed [31:0]  i_measured_angle,
    input  logic signed [31:0]  i_angular_rate,

    output logic                o_valid,
    input  logic                i_ready,
    output logic signed [31:0]  o_angle_estimate,
    output logic [31:0]         o_error_variance
);

    localparam int QB = FRAC_BITS + 1;
    localparam int NW = FRAC_BITS + 33;
    localparam int MA = 34;
    localparam int MB = (FRAC_BITS + 2 > 17) ? FRAC_BITS + 2 : 17;
    localparam int PW = MA + MB;
    localparam int SW = PW + 2;
    localparam int CW = $clog2(QB);
    localparam logic [QB-1:0] K_ONE = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic signed [PW:0] RND_HALF =
        {{(PW + 1 - FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS - 1){1'b0}}};

    typedef enum logic [3:0] {
        S_IDLE, S_PRED, S_SUM, S_DINIT, S_DIV, S_MULK, S_XUPD, S_PUPD, S_OUT
    } t_state;

    t_state                 r_state, n_state;

    logic [15:0]            r_dt;
    logic [31:0]            r_q_noise;
    logic [31:0]            r_r_noise;

    logic signed [31:0]     r_est;
    logic [31:0]            r_var;

    logic signed [31:0]     r_e;
    logic signed [31:0]     r_w;
    logic signed [31:0]     r_x;
    logic [31:0]            r_p;
    logic [32:0]            r_s;
    logic signed [32:0]     r_diff;
    logic [32:0]            r_rem;
    logic [QB-1:0]          r_nlo;
    logic [QB-1:0]          r_quo;
    logic [CW-1:0]          r_cnt;
    logic [QB-1:0]          r_kc;
    logic signed [PW-1:0]   r_prod;

    logic                   w_cfg_wr;
    logic [1:0]             w_cfg_idx;
    logic                   w_in_acc;

    logic signed [MA-1:0]   w_mul_a;
    logic signed [MB-1:0]   w_mul_b;
    logic signed [PW:0]     w_rnd_sum;
    logic signed [PW:0]     w_rnd;
    logic signed [SW-1:0]   w_x_sum;
    logic signed [31:0]     w_x_base;

    logic [32:0]            w_pq_sum;
    logic [NW-1:0]          w_num;
    logic [33:0]            w_trial;
    logic [33:0]            w_trial_sub;
    logic                   w_ge;
    logic [QB-1:0]          w_k;

    function automatic logic signed [31:0] sat_s32(input logic signed [SW-1:0] v);
        if (&v[SW-1:31] || ~|v[SW-1:31]) begin
            return v[31:0];
        end
        return v[SW-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    endfunction

    // configuration port
    assign pready    = 1'b1;
    assign w_cfg_idx = paddr[3:2];
    assign w_cfg_wr  = psel & penable & pwrite;

    always_comb begin
        unique case (w_cfg_idx)
            REG_STEP_TIME:     prdata = {16'd0, r_dt};
            REG_PROCESS_NOISE: prdata = r_q_noise;
            REG_MEAS_NOISE:    prdata = r_r_noise;
            default:           prdata = '0;
        endcase
    end

    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = (r_state == S_OUT);
    assign w_in_acc = i_valid & o_ready;
    assign o_angle_estimate = r_est;
    assign o_error_variance = r_var;

    // shared multiplier operands
    always_comb begin
        case (r_state)
            S_PRED: begin
                w_mul_a = {{(MA - 32){r_w[31]}}, r_w};
                w_mul_b = {{(MB - 16){1'b0}}, r_dt};
            end
            S_MULK: begin
                w_mul_a = {{(MA - 33){r_diff[32]}}, r_diff};
                w_mul_b = {{(MB - QB){1'b0}}, w_k};
            end
            S_XUPD: begin
                w_mul_a = {{(MA - 32){1'b0}}, r_p};
                w_mul_b = {{(MB - QB){1'b0}}, r_kc};
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    // round to nearest, ties up, then add to the estimate
    assign w_rnd_sum = $signed({r_prod[PW-1], r_prod}) + RND_HALF;
    assign w_rnd     = w_rnd_sum >>> FRAC_BITS;
    assign w_x_base  = (r_state == S_SUM) ? r_est : r_x;
    assign w_x_sum   = $signed({w_rnd[PW], w_rnd})
                     + $signed({{(SW - 32){w_x_base[31]}}, w_x_base});

    assign w_pq_sum  = {1'b0, r_var} + {1'b0, r_q_noise};
    assign w_num     = {1'b0, r_p, {FRAC_BITS{1'b0}}} + {{(FRAC_BITS + 1){1'b0}}, r_s[32:1]};

    // restoring divider step
    assign w_trial     = {r_rem, r_nlo[QB-1]};
    assign w_trial_sub = w_trial - {1'b0, r_s};
    assign w_ge        = (w_trial >= {1'b0, r_s});
    assign w_k         = (r_s == '0) ? '0 : r_quo;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = (i_req_type == req_restart) ? S_OUT : S_PRED;
                end
            end
            S_PRED:  n_state = S_SUM;
            S_SUM:   n_state = S_DINIT;
            S_DINIT: n_state = S_DIV;
            S_DIV: begin
                if (r_cnt == '0) begin
                    n_state = S_MULK;
                end
            end
            S_MULK:  n_state = S_XUPD;
            S_XUPD:  n_state = S_PUPD;
            S_PUPD:  n_state = S_OUT;
            S_OUT: begin
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_dt      <= STEP_TIME_RST;
            r_q_noise <= PROCESS_NOISE_RST;
            r_r_noise <= MEAS_NOISE_RST;
            r_est     <= '0;
            r_var     <= '0;
        end else begin
            r_state <= n_state;
            if (w_cfg_wr) begin
                unique case (w_cfg_idx)
                    REG_STEP_TIME:     r_dt      <= pwdata[15:0];
                    REG_PROCESS_NOISE: r_q_noise <= pwdata;
                    REG_MEAS_NOISE:    r_r_noise <= pwdata;
                    default: ;
                endcase
            end
            if (w_in_acc && i_req_type == req_restart) begin
                r_est <= '0;
                r_var <= '0;
            end
            if (r_state == S_XUPD) begin
                r_est <= sat_s32(w_x_sum);
            end
            if (r_state == S_PUPD) begin
                r_var <= w_rnd[31:0];
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= w_mul_a * w_mul_b;
        unique case (r_state)
            S_IDLE: begin
                r_e <= i_measured_angle;
                r_w <= i_angular_rate;
            end
            S_PRED: begin
                r_p <= w_pq_sum[32] ? 32'hffff_ffff : w_pq_sum[31:0];
            end
            S_SUM: begin
                r_x <= sat_s32(w_x_sum);
                r_s <= {1'b0, r_p} + {1'b0, r_r_noise};
            end
            S_DINIT: begin
                r_diff <= {r_e[31], r_e} - {r_x[31], r_x};
                r_rem  <= {1'b0, w_num[NW-1:QB]};
                r_nlo  <= w_num[QB-1:0];
                r_cnt  <= CW'(QB - 1);
            end
            S_DIV: begin
                r_rem <= w_ge ? w_trial_sub[32:0] : w_trial[32:0];
                r_nlo <= {r_nlo[QB-2:0], 1'b0};
                r_quo <= {r_quo[QB-2:0], w_ge};
                r_cnt <= r_cnt - 1'b1;
            end
            S_MULK: begin
                r_kc <= K_ONE - w_k;
            end
            default: ;
        endcase
    end

    a_no_dual_handshake: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_valid && o_ready))
        else $error("ready and result valid high together");

    a_restart_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_req_type == req_restart) |=>
        (o_valid && o_angle_estimate == 32'sd0 && o_error_variance == 32'd0))
        else $error("restart item did not clear the state");

    a_gain_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MULK) |-> (w_k <= K_ONE))
        else $error("gain above one");

    a_variance_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUPD) |=> (r_var <= $past(r_p)))
        else $error("corrected variance above predicted variance");

endmodule
